// ===== rtl/fae_pkg.sv =====
package fae_pkg;

  // Number of axes that carry input and output fields
  localparam int IN_AXES = 4;
  localparam int IN_AX_W = 2;

  // Configuration register index space
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 31;
  localparam logic [CFG_IDX_W-1:0] REG_INV_MASS_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING_X = 3'd4;

  // Reset values of the configuration registers (1.0 and 100.0 in unsigned Q15.16)
  localparam logic [CFG_DATA_W-1:0] INV_MASS_RST = 31'd65536;
  localparam logic [CFG_DATA_W-1:0] DAMPING_RST = 31'd6553600;

  // Multiplier operand selection
  localparam logic [1:0] MUL_DAMP = 2'd0;
  localparam logic [1:0] MUL_VSTEP = 2'd1;
  localparam logic [1:0] MUL_INVM = 2'd2;
  localparam logic [1:0] MUL_ASTEP = 2'd3;

  typedef struct packed {
    logic ld_in;
    logic ld_force;
    logic ld_diff;
    logic ld_np;
    logic ld_acc;
    logic ld_nv;
    logic commit;
    logic mul_en;
    logic [1:0] mul_sel;
    logic ld_out;
  } dp_cmd_t;

endpackage

// ===== rtl/fae_ctrl.sv =====
module fae_ctrl
  import fae_pkg::*;
#(
  parameter int RUN_AXES = 4,
  parameter int AX_W = 2
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  output dp_cmd_t         cmd,
  output logic [AX_W-1:0] axis
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CALC = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  localparam logic [2:0] PH_DAMP = 3'd0;
  localparam logic [2:0] PH_DIFF = 3'd1;
  localparam logic [2:0] PH_INVM = 3'd2;
  localparam logic [2:0] PH_ACC = 3'd3;
  localparam logic [2:0] PH_ASTEP = 3'd4;
  localparam logic [2:0] PH_NV = 3'd5;
  localparam logic [2:0] PH_COMMIT = 3'd6;

  localparam logic [AX_W-1:0] AXIS_LAST = AX_W'(RUN_AXES - 1);

  logic [1:0] state;
  logic [1:0] state_next;
  logic [2:0] phase;
  logic [2:0] phase_next;
  logic [AX_W-1:0] axis_next;
  logic out_valid_next;

  assign in_stall = (state != ST_IDLE);

  // Decode phase into datapath commands
  always_comb begin
    cmd = '0;
    cmd.mul_sel = MUL_DAMP;
    cmd.ld_in = in_valid && (state == ST_IDLE);
    cmd.ld_out = (state == ST_FLUSH) && (!out_valid || !out_stall);
    if (state == ST_CALC) begin
      unique case (phase)
        PH_DAMP: begin
          cmd.mul_en = 1'b1;
          cmd.mul_sel = MUL_DAMP;
          cmd.ld_force = 1'b1;
        end
        PH_DIFF: begin
          cmd.ld_diff = 1'b1;
          cmd.mul_en = 1'b1;
          cmd.mul_sel = MUL_VSTEP;
        end
        PH_INVM: begin
          cmd.ld_np = 1'b1;
          cmd.mul_en = 1'b1;
          cmd.mul_sel = MUL_INVM;
        end
        PH_ACC: cmd.ld_acc = 1'b1;
        PH_ASTEP: begin
          cmd.mul_en = 1'b1;
          cmd.mul_sel = MUL_ASTEP;
        end
        PH_NV: cmd.ld_nv = 1'b1;
        PH_COMMIT: cmd.commit = 1'b1;
        default: cmd.mul_sel = MUL_DAMP;
      endcase
    end
  end

  // Sequence phases and axes
  always_comb begin
    state_next = state;
    phase_next = phase;
    axis_next = axis;
    unique case (state)
      ST_IDLE: begin
        if (cmd.ld_in) begin
          state_next = ST_CALC;
          phase_next = PH_DAMP;
          axis_next = '0;
        end
      end
      ST_CALC: begin
        if (phase == PH_COMMIT) begin
          phase_next = PH_DAMP;
          if (axis == AXIS_LAST) begin
            state_next = ST_FLUSH;
          end else begin
            axis_next = axis + 1'b1;
          end
        end else begin
          phase_next = phase + 1'b1;
        end
      end
      ST_FLUSH: begin
        if (cmd.ld_out) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Hold the result beat until taken
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.ld_out) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      phase <= PH_DAMP;
      axis <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      axis <= axis_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ===== rtl/fae_dp.sv =====
module fae_dp
  import fae_pkg::*;
#(
  parameter int RUN_AXES = 4,
  parameter int AX_W = 2,
  parameter int STEP_Q16 = 655
) (
  input  logic                         clk,
  input  logic                         rst,
  input  dp_cmd_t                      cmd,
  input  logic [AX_W-1:0]              axis,
  input  logic                         cfg_we,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_data,
  input  logic [IN_AXES-1:0][31:0]     force_vec,
  input  logic [IN_AXES-1:0][31:0]     assist_vec,
  input  logic                         hold,
  output logic [IN_AXES-1:0][31:0]     pos_vec,
  output logic [IN_AXES-1:0][31:0]     vel_vec
);

  localparam logic signed [32:0] STEP_S = 33'(STEP_Q16);

  // Clamp a 33-bit sum to the signed 32-bit range
  function automatic logic [31:0] sat33(input logic signed [32:0] x);
    logic [31:0] r;
    if (x[32] != x[31]) begin
      r = x[32] ? 32'h8000_0000 : 32'h7fff_ffff;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  // Clamp a 48-bit shifted product to the signed 32-bit range
  function automatic logic [31:0] sat48(input logic signed [47:0] x);
    logic [31:0] r;
    if ((&x[47:31]) || !(|x[47:31])) begin
      r = x[31:0];
    end else begin
      r = x[47] ? 32'h8000_0000 : 32'h7fff_ffff;
    end
    return r;
  endfunction

  // Magnitude at full width, so the most negative value stays positive
  function automatic logic [32:0] mag33(input logic [31:0] x);
    logic [32:0] e;
    e = {x[31], x};
    return x[31] ? (33'd0 - e) : e;
  endfunction

  logic [CFG_DATA_W-1:0] inv_mass [IN_AXES];
  logic [CFG_DATA_W-1:0] damping [IN_AXES];
  logic [31:0] force_in [IN_AXES];
  logic [31:0] assist_in [IN_AXES];
  logic hold_in;
  logic [31:0] vel_st [RUN_AXES];
  logic [31:0] pos_st [RUN_AXES];

  logic [IN_AX_W-1:0] ax_in;
  logic [31:0] v_cur;
  logic [31:0] p_cur;
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod_full;
  logic signed [63:0] prod;
  logic signed [47:0] prod_q;
  logic [31:0] prod_sat;
  logic [31:0] f_reg;
  logic [31:0] diff;
  logic [31:0] acc;
  logic [31:0] nv;
  logic [31:0] np;
  logic blocked;

  assign ax_in = IN_AX_W'(axis);
  assign v_cur = vel_st[axis];
  assign p_cur = pos_st[axis];

  // Floor of product / 2^16, then clamp
  assign prod_q = prod[63:16];
  assign prod_sat = sat48(prod_q);

  // Select operands of the shared multiplier
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_DAMP: begin
        mul_a = $signed({2'b00, damping[ax_in]});
        mul_b = $signed({v_cur[31], v_cur});
      end
      MUL_VSTEP: begin
        mul_a = STEP_S;
        mul_b = $signed({v_cur[31], v_cur});
      end
      MUL_INVM: begin
        mul_a = $signed({2'b00, inv_mass[ax_in]});
        mul_b = $signed({diff[31], diff});
      end
      MUL_ASTEP: begin
        mul_a = STEP_S;
        mul_b = $signed({acc[31], acc});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_full = mul_a * mul_b;

  // Hold back motion that grows the position magnitude
  assign blocked = hold_in && (mag33(np) > mag33(p_cur));

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < IN_AXES; i++) begin
        inv_mass[i] <= INV_MASS_RST;
        damping[i] <= DAMPING_RST;
      end
    end else if (cfg_we) begin
      if (cfg_index < REG_DAMPING_X) begin
        inv_mass[IN_AX_W'(cfg_index - REG_INV_MASS_X)] <= cfg_data;
      end else begin
        damping[IN_AX_W'(cfg_index - REG_DAMPING_X)] <= cfg_data;
      end
    end
  end

  // Velocity and position stores
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RUN_AXES; i++) begin
        vel_st[i] <= '0;
        pos_st[i] <= '0;
      end
    end else if (cmd.commit) begin
      if (blocked) begin
        vel_st[axis] <= '0;
      end else begin
        vel_st[axis] <= nv;
        pos_st[axis] <= np;
      end
    end
  end

  // Input capture and working registers
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      for (int i = 0; i < IN_AXES; i++) begin
        force_in[i] <= force_vec[i];
        assist_in[i] <= assist_vec[i];
      end
      hold_in <= hold;
    end
    if (cmd.mul_en) begin
      prod <= prod_full[63:0];
    end
    if (cmd.ld_force) begin
      f_reg <= sat33($signed({assist_in[ax_in][31], assist_in[ax_in]})
                     + $signed({force_in[ax_in][31], force_in[ax_in]}));
    end
    if (cmd.ld_diff) begin
      diff <= sat33($signed({f_reg[31], f_reg}) - $signed({prod_sat[31], prod_sat}));
    end
    if (cmd.ld_np) begin
      np <= sat33($signed({p_cur[31], p_cur}) + $signed({prod_sat[31], prod_sat}));
    end
    if (cmd.ld_acc) begin
      acc <= prod_sat;
    end
    if (cmd.ld_nv) begin
      nv <= sat33($signed({v_cur[31], v_cur}) + $signed({prod_sat[31], prod_sat}));
    end
  end

  // Result register; absent axes read as zero
  for (genvar g = 0; g < IN_AXES; g++) begin : g_out
    if (g < RUN_AXES) begin : g_run
      always_ff @(posedge clk) begin
        if (cmd.ld_out) begin
          pos_vec[g] <= pos_st[g];
          vel_vec[g] <= vel_st[g];
        end
      end
    end else begin : g_absent
      assign pos_vec[g] = '0;
      assign vel_vec[g] = '0;
    end
  end

endmodule

// ===== rtl/four_axis_admittance_euler.sv =====
// One shared 33x33 multiplier steps through seven phases per axis, and a result
// register holds each beat; no new input beat is taken until the last result is staged.
// Reset (rst, synchronous, active high) zeroes velocities and positions, sets
// reciprocal masses to 1.0 and damping to 100.0, and empties the result stage.
// Configuration writes are taken every cycle.
module four_axis_admittance_euler
  import fae_pkg::*;
#(
  parameter int AXES = 4,
  parameter int STEP_Q16 = 655
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic signed [31:0]    force_x,
  input  logic signed [31:0]    force_z,
  input  logic signed [31:0]    moment_theta,
  input  logic signed [31:0]    moment_psi,
  input  logic signed [31:0]    assist_x,
  input  logic signed [31:0]    assist_z,
  input  logic signed [31:0]    assist_theta,
  input  logic signed [31:0]    assist_psi,
  input  logic                  saturation_hold,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic signed [31:0]    pos_x,
  output logic signed [31:0]    pos_z,
  output logic signed [31:0]    pos_theta,
  output logic signed [31:0]    pos_psi,
  output logic signed [31:0]    vel_x,
  output logic signed [31:0]    vel_z,
  output logic signed [31:0]    vel_theta,
  output logic signed [31:0]    vel_psi,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int RUN_AXES = (AXES < IN_AXES) ? AXES : IN_AXES;
  localparam int AX_W = (RUN_AXES > 1) ? $clog2(RUN_AXES) : 1;

  dp_cmd_t cmd;
  logic [AX_W-1:0] axis;
  logic [IN_AXES-1:0][31:0] force_vec;
  logic [IN_AXES-1:0][31:0] assist_vec;
  logic [IN_AXES-1:0][31:0] pos_vec;
  logic [IN_AXES-1:0][31:0] vel_vec;

  assign cfg_ready = 1'b1;

  // Gather input fields by axis
  assign force_vec = {moment_psi, moment_theta, force_z, force_x};
  assign assist_vec = {assist_psi, assist_theta, assist_z, assist_x};

  // Spread result fields
  assign pos_x = pos_vec[0];
  assign pos_z = pos_vec[1];
  assign pos_theta = pos_vec[2];
  assign pos_psi = pos_vec[3];
  assign vel_x = vel_vec[0];
  assign vel_z = vel_vec[1];
  assign vel_theta = vel_vec[2];
  assign vel_psi = vel_vec[3];

  fae_ctrl #(
    .RUN_AXES(RUN_AXES),
    .AX_W(AX_W)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd(cmd),
    .axis(axis)
  );

  fae_dp #(
    .RUN_AXES(RUN_AXES),
    .AX_W(AX_W),
    .STEP_Q16(STEP_Q16)
  ) u_dp (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .axis(axis),
    .cfg_we(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .force_vec(force_vec),
    .assist_vec(assist_vec),
    .hold(saturation_hold),
    .pos_vec(pos_vec),
    .vel_vec(vel_vec)
  );

`ifndef NO_ASSERTIONS
  // An accepted beat closes the input until the result is staged
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after an accepted beat");

  // A staged result is presented on the next cycle
  a_load_shows_result: assert property (@(posedge clk) disable iff (rst)
    cmd.ld_out |=> out_valid)
    else $error("result load without valid output");

  // Capture, store update and result load never coincide
  a_cmd_exclusive: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.ld_in, cmd.commit, cmd.ld_out}))
    else $error("conflicting datapath commands");

  // Stores only change while an item is in work
  a_commit_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> in_stall)
    else $error("store update while idle");
`endif

endmodule
